[design/slc_pkg.sv]
package slc_pkg;

  localparam int WAYS         = 8;
  localparam int MAX_SET_BITS = 6;
  localparam int SETS         = 1 << MAX_SET_BITS;
  localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W       = $clog2(WAYS + 1);
  localparam int AGE_W        = WAY_W;
  localparam int TAG_W        = 62;
  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 32;
  localparam int MAX_OFF_BITS = 16;

  localparam int SB_W  = 3;
  localparam int OB_W  = 5;
  localparam int WR_W  = 4;
  localparam int CFG_W = 5;
  localparam int CFG_A = 2;

  localparam int OUT_FIELDS_W = 2 + 1 + 1 + 3 * CNT_W;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [CFG_A-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_A-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CFG_A-1:0] CFG_WAYS     = 2'd2;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  typedef struct packed {
    logic             vld;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic hit;
    logic evict;
    row_t new_row;
  } lk_res_t;

endpackage

[design/slc_set_ram.sv]
module slc_set_ram (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [slc_pkg::MAX_SET_BITS-1:0] rd_addr,
  input  logic                             wr_en,
  input  logic [slc_pkg::MAX_SET_BITS-1:0] wr_addr,
  input  slc_pkg::row_t                    wr_data,
  output slc_pkg::row_t                    rd_data
);
  import slc_pkg::*;

  row_t            mem [SETS];
  logic [SETS-1:0] row_vld_r;
  row_t            rd_data_r;
  logic            rd_ok_r;

  // rows never written read as empty
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule

[design/slc_lookup.sv]
module slc_lookup (
  input  slc_pkg::row_t              row,
  input  logic [slc_pkg::TAG_W-1:0]  tag,
  input  logic [slc_pkg::WCNT_W-1:0] ways,
  output slc_pkg::lk_res_t           res
);
  import slc_pkg::*;

  logic             hit_found;
  logic [WAY_W-1:0] hit_w;
  logic             emp_found;
  logic [WAY_W-1:0] emp_w;
  logic [AGE_W-1:0] max_age;
  logic [WAY_W-1:0] vic_w;
  logic [WAY_W-1:0] tgt_w;
  logic [AGE_W-1:0] old_age;
  logic             grow_all;
  row_t             nrow;

  always_comb begin
    hit_found = 1'b0;
    hit_w     = '0;
    emp_found = 1'b0;
    emp_w     = '0;
    max_age   = row[0].age;
    vic_w     = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (WCNT_W'(i) < ways && row[i].vld && row[i].tag == tag && !hit_found) begin
        hit_found = 1'b1;
        hit_w     = WAY_W'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (WCNT_W'(i) < ways && !row[i].vld) begin
        emp_found = 1'b1;
        emp_w     = WAY_W'(i);
      end
    end
    // lowest way among the oldest
    for (int i = 1; i < WAYS; i++) begin
      if (WCNT_W'(i) < ways && row[i].age > max_age) begin
        max_age = row[i].age;
        vic_w   = WAY_W'(i);
      end
    end

    if (hit_found) begin
      tgt_w    = hit_w;
      old_age  = row[hit_w].age;
      grow_all = 1'b0;
    end else if (emp_found) begin
      tgt_w    = emp_w;
      old_age  = '0;
      grow_all = 1'b1;
    end else begin
      tgt_w    = vic_w;
      old_age  = max_age;
      grow_all = 1'b0;
    end

    nrow = row;
    for (int i = 0; i < WAYS; i++) begin
      if (WCNT_W'(i) < ways && WAY_W'(i) != tgt_w && row[i].vld &&
          (grow_all || row[i].age < old_age) && row[i].age != AGE_MAX) begin
        nrow[i].age = row[i].age + 1'b1;
      end
    end
    nrow[tgt_w].vld = 1'b1;
    nrow[tgt_w].tag = tag;
    nrow[tgt_w].age = '0;

    res.hit     = hit_found;
    res.evict   = !hit_found && !emp_found;
    res.new_row = nrow;
  end

endmodule

[design/set_assoc_lru_cache_sim_core.sv]
// channel  dir  signals                       payload
// in       in   in_tvalid/in_tready           tuser: req_type; tdata: address
// out      out  out_tvalid/out_tready         tdata: hits, miss, evict, three totals
// cfg      in   cfg_we/cfg_addr/cfg_wdata     set_index_bits, offset_bits, ways_in_use
//
// an access steps through accept, set row read, then lookup and row write-back
// set memory: one row of all ways per set; next access waits for the last write-back
// a modify costs the same as a load or store
// reset is synchronous; set rows read as empty until first written, no clearing pass
// a held result stalls the write-back until out_tready

module set_assoc_lru_cache_sim_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [1:0]                  in_tuser,   // [1:0] req_type
  input  logic [slc_pkg::ADDR_W-1:0]  in_tdata,   // [63:0] address
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] hits_now, [2] miss_now, [3] evicted_now, [35:4] hit_total,
  // [67:36] miss_total, [99:68] eviction_total, [103:100] zero
  output logic [slc_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_we,
  input  logic [slc_pkg::CFG_A-1:0]   cfg_addr,
  input  logic [slc_pkg::CFG_W-1:0]   cfg_wdata
);
  import slc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]              st_r, st_nxt;
  logic [SB_W-1:0]         sb_r;
  logic [OB_W-1:0]         ob_r;
  logic [WR_W-1:0]         ways_r;
  logic [SB_W-1:0]         sb_c;
  logic [OB_W-1:0]         ob_c;
  logic [WCNT_W-1:0]       ways_c;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [ADDR_W-1:0]       addr_sh;
  logic [5:0]              tag_sh;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [TAG_W-1:0]        tag_r;
  logic [1:0]              req_r;
  logic [WCNT_W-1:0]       ways_q_r;
  row_t                    rd_row;
  lk_res_t                 lk;
  logic                    do_upd;
  logic                    access;
  logic [1:0]              hits_now;
  logic                    miss_now;
  logic                    evict_now;
  logic [CNT_W-1:0]        hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [CNT_W-1:0]        hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;
  logic                    out_vld_r;
  logic [OUT_W-1:0]        out_data_r;
  logic                    in_xfer;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r   <= SB_W'(4);
      ob_r   <= OB_W'(4);
      ways_r <= WR_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SET_BITS: sb_r   <= cfg_wdata[SB_W-1:0];
        CFG_OFF_BITS: ob_r   <= cfg_wdata[OB_W-1:0];
        CFG_WAYS:     ways_r <= cfg_wdata[WR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sb_r == '0) sb_c = SB_W'(1);
    else if (sb_r > SB_W'(MAX_SET_BITS)) sb_c = SB_W'(MAX_SET_BITS);
    else sb_c = sb_r;
    if (ob_r == '0) ob_c = OB_W'(1);
    else if (ob_r > OB_W'(MAX_OFF_BITS)) ob_c = OB_W'(MAX_OFF_BITS);
    else ob_c = ob_r;
    if (ways_r == '0) ways_c = WCNT_W'(1);
    else if ({1'b0, ways_r} > 5'(WAYS)) ways_c = WCNT_W'(WAYS);
    else ways_c = WCNT_W'(ways_r);
  end

  assign set_mask = ~({MAX_SET_BITS{1'b1}} << sb_c);
  assign addr_sh  = in_tdata >> ob_c;
  assign tag_sh   = {3'b000, sb_c} + {1'b0, ob_c};

  assign in_tready = (st_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      set_r    <= addr_sh[MAX_SET_BITS-1:0] & set_mask;
      tag_r    <= TAG_W'(in_tdata >> tag_sh);
      req_r    <= in_tuser;
      ways_q_r <= ways_c;
    end
  end

  assign do_upd = (st_r == ST_UPD) && (!out_vld_r || out_tready);
  assign access = (req_r != REQ_NONE);

  slc_set_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (st_r == ST_RD),
    .rd_addr (set_r),
    .wr_en   (do_upd && access),
    .wr_addr (set_r),
    .wr_data (lk.new_row),
    .rd_data (rd_row)
  );

  slc_lookup u_lookup (
    .row  (rd_row),
    .tag  (tag_r),
    .ways (ways_q_r),
    .res  (lk)
  );

  // second access of a modify always hits and leaves the row unchanged
  always_comb begin
    hits_now  = 2'd0;
    miss_now  = 1'b0;
    evict_now = 1'b0;
    if (access) begin
      hits_now  = {1'b0, lk.hit} + {1'b0, req_r == REQ_MODIFY};
      miss_now  = !lk.hit;
      evict_now = lk.evict;
    end
    hit_cnt_nxt   = hit_cnt_r + CNT_W'(hits_now);
    miss_cnt_nxt  = miss_cnt_r + CNT_W'(miss_now);
    evict_cnt_nxt = evict_cnt_r + CNT_W'(evict_now);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_xfer) st_nxt = ST_RD;
      ST_RD:   st_nxt = ST_UPD;
      ST_UPD:  if (do_upd) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (do_upd) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
        out_vld_r   <= 1'b1;
      end else if (out_tready) begin
        out_vld_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_upd) begin
      out_data_r <= OUT_W'({evict_cnt_nxt, miss_cnt_nxt, hit_cnt_nxt,
                            evict_now, miss_now, hits_now});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

[design/slc_chk.sv]
module slc_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [slc_pkg::OUT_W-1:0]  out_tdata
);
  import slc_pkg::*;

  logic [1:0] hits_f;
  logic       miss_f;
  logic       evict_f;

  assign hits_f  = out_tdata[1:0];
  assign miss_f  = out_tdata[2];
  assign evict_f = out_tdata[3];

  // one item in flight: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(evict_f && !miss_f))
    else $error("eviction without a miss");

  a_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hits_f != 2'd3 && !(hits_f == 2'd2 && miss_f))
    else $error("hit and miss counts inconsistent");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the channels");

endmodule

bind set_assoc_lru_cache_sim_core slc_chk u_slc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
